// File: hw/rtl/shortest_remaining_time_scheduler_assert.svh
// Assertion macros used by the scheduler controller.
`ifndef SHORTEST_REMAINING_TIME_SCHEDULER_ASSERT_SVH
`define SHORTEST_REMAINING_TIME_SCHEDULER_ASSERT_SVH

// Clocked check, suspended while reset is asserted.
`define SRTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define SRTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/srts_pkg.sv
package srts_pkg;

    localparam int MAX_JOBS_DEF = 16;
    localparam int SLOT_FIELD_W = 4;
    localparam int TIME_W       = 32;
    localparam int BURST_W      = 16;
    localparam int COUNT_W      = 5;

    localparam logic [COUNT_W-1:0] JOB_COUNT_RST = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic load;       // write a job slot from the input transfer
        logic scan_init;  // clear the scan index and the running best
        logic scan_step;  // read the slot at the scan index, advance it
        logic update;     // advance time, charge one unit to the pick
        logic calc_tat;   // form the turnaround time
        logic emit;       // register the result and strobe it
    } t_cmd;

    typedef struct packed {
        logic scan_last;  // scan index sits on the final slot
        logic pick_vld;   // an eligible job was found
        logic pick_last;  // the pick has one unit left
    } t_status;

endpackage

// File: hw/rtl/srts_ram.sv
module srts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/srts_datapath.sv
module srts_datapath #(
    parameter int MAX_JOBS = srts_pkg::MAX_JOBS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  srts_pkg::t_cmd                    i_cmd,
    output srts_pkg::t_status                 o_status,
    input  logic                              i_cfg_we,
    input  logic [srts_pkg::COUNT_W-1:0]      i_job_count,
    input  logic [srts_pkg::SLOT_FIELD_W-1:0] i_job_slot,
    input  logic [srts_pkg::TIME_W-1:0]       i_arrival_time,
    input  logic [srts_pkg::BURST_W-1:0]      i_burst_length,
    output logic                              o_result_valid,
    output logic [srts_pkg::SLOT_FIELD_W-1:0] o_finished_slot,
    output logic [srts_pkg::TIME_W-1:0]       o_completion_time,
    output logic [srts_pkg::TIME_W-1:0]       o_turnaround_time,
    output logic [srts_pkg::TIME_W-1:0]       o_waiting_time,
    output logic                              o_all_done
);

    import srts_pkg::*;

    localparam int SLOT_W = $clog2(MAX_JOBS);
    localparam int EXT_W  = ((SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W) + 1;

    // control state
    logic [TIME_W-1:0]   r_time;
    logic [COUNT_W-1:0]  r_fin_count;
    logic [COUNT_W-1:0]  r_job_count;
    logic [MAX_JOBS-1:0] r_loaded;
    logic [SLOT_W-1:0]   r_idx;
    logic                r_cmp_vld;
    logic                r_pick_vld;
    logic                r_res_valid;

    // payload
    logic [SLOT_W-1:0]   r_cmp_idx;
    logic [SLOT_W-1:0]   r_pick;
    logic [BURST_W-1:0]  r_best_rem;
    logic [TIME_W-1:0]   r_best_arr;
    logic [BURST_W-1:0]  r_best_burst;
    logic [TIME_W-1:0]   r_tat;
    logic [SLOT_FIELD_W-1:0] r_res_slot;
    logic [TIME_W-1:0]   r_res_ct;
    logic [TIME_W-1:0]   r_res_tat;
    logic [TIME_W-1:0]   r_res_wt;
    logic                r_res_all;

    logic [EXT_W-1:0]    slot_ext;
    logic [SLOT_W-1:0]   slot_addr;
    logic                load_ok;
    logic                ram_we_job;
    logic                ram_we_rem;
    logic [SLOT_W-1:0]   rem_waddr;
    logic [BURST_W-1:0]  rem_wdata;
    logic [TIME_W-1:0]   rd_arr;
    logic [BURST_W-1:0]  rd_burst;
    logic [BURST_W-1:0]  rd_rem;
    logic                eligible;
    logic                better;
    logic [EXT_W-1:0]    pick_ext;

    assign slot_ext  = EXT_W'(i_job_slot);
    assign slot_addr = slot_ext[SLOT_W-1:0];
    assign load_ok   = i_cmd.load && (i_burst_length != '0)
                     && (slot_ext < EXT_W'(MAX_JOBS));

    assign ram_we_job = load_ok;
    assign ram_we_rem = load_ok || (i_cmd.update && r_pick_vld);
    assign rem_waddr  = load_ok ? slot_addr : r_pick;
    assign rem_wdata  = load_ok ? i_burst_length : (r_best_rem - BURST_W'(1));

    srts_ram #(.WIDTH(TIME_W), .DEPTH(MAX_JOBS)) u_arr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we_job),
        .i_waddr (slot_addr),
        .i_wdata (i_arrival_time),
        .i_raddr (r_idx),
        .o_rdata (rd_arr)
    );

    srts_ram #(.WIDTH(BURST_W), .DEPTH(MAX_JOBS)) u_burst_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we_job),
        .i_waddr (slot_addr),
        .i_wdata (i_burst_length),
        .i_raddr (r_idx),
        .o_rdata (rd_burst)
    );

    srts_ram #(.WIDTH(BURST_W), .DEPTH(MAX_JOBS)) u_rem_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we_rem),
        .i_waddr (rem_waddr),
        .i_wdata (rem_wdata),
        .i_raddr (r_idx),
        .o_rdata (rd_rem)
    );

    // strict less keeps the lower slot on a tie
    assign eligible = r_cmp_vld && r_loaded[r_cmp_idx] && (rd_rem != '0)
                    && (rd_arr <= r_time);
    assign better   = eligible && (!r_pick_vld || (rd_rem < r_best_rem));

    assign pick_ext = EXT_W'(r_pick);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= '0;
            r_fin_count <= '0;
            r_job_count <= JOB_COUNT_RST;
            r_loaded    <= '0;
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_pick_vld  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_job_count <= i_job_count;
            end
            if (load_ok) begin
                r_loaded[slot_addr] <= 1'b1;
            end
            r_cmp_vld   <= i_cmd.scan_step;
            r_res_valid <= i_cmd.emit;
            if (i_cmd.scan_init) begin
                r_idx      <= '0;
                r_pick_vld <= 1'b0;
            end else begin
                if (i_cmd.scan_step) begin
                    r_idx <= r_idx + SLOT_W'(1);
                end
                if (better) begin
                    r_pick_vld <= 1'b1;
                end
            end
            if (i_cmd.update) begin
                if (r_time != '1) begin
                    r_time <= r_time + TIME_W'(1);
                end
                if (r_pick_vld && (r_best_rem == BURST_W'(1))
                        && (r_fin_count != COUNT_MAX)) begin
                    r_fin_count <= r_fin_count + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx;
        if (better) begin
            r_pick       <= r_cmp_idx;
            r_best_rem   <= rd_rem;
            r_best_arr   <= rd_arr;
            r_best_burst <= rd_burst;
        end
        if (i_cmd.calc_tat) begin
            r_tat <= r_time - r_best_arr;
        end
        if (i_cmd.emit) begin
            r_res_slot <= pick_ext[SLOT_FIELD_W-1:0];
            r_res_ct   <= r_time;
            r_res_tat  <= r_tat;
            // clamp at zero once time has saturated
            r_res_wt   <= (r_tat >= TIME_W'(r_best_burst))
                        ? (r_tat - TIME_W'(r_best_burst)) : '0;
            r_res_all  <= (r_fin_count >= r_job_count);
        end
    end

    assign o_status.scan_last = (r_idx == SLOT_W'(MAX_JOBS - 1));
    assign o_status.pick_vld  = r_pick_vld;
    assign o_status.pick_last = (r_best_rem == BURST_W'(1));

    assign o_result_valid    = r_res_valid;
    assign o_finished_slot   = r_res_slot;
    assign o_completion_time = r_res_ct;
    assign o_turnaround_time = r_res_tat;
    assign o_waiting_time    = r_res_wt;
    assign o_all_done        = r_res_all;

endmodule

// File: hw/rtl/srts_ctrl.sv
`include "shortest_remaining_time_scheduler_assert.svh"

module srts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              i_operation,
    output logic              busy,
    output srts_pkg::t_cmd    o_cmd,
    input  srts_pkg::t_status i_status
);

    import srts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_UPDATE,
        S_TAT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   accept;

    assign accept = start && !r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_operation == OP_LOAD)) begin
                    o_cmd.load = 1'b1;
                end else if (accept) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state = (i_status.pick_vld && i_status.pick_last) ? S_TAT : S_IDLE;
            end
            S_TAT: begin
                o_cmd.calc_tat = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign busy = r_busy;

    `SRTS_ASSERT(a_tick_starts_scan, i_clk, i_rst_n, (accept && (i_operation == OP_TICK)) |=> (r_state == S_SCAN), "tick transfer did not start a scan")
    `SRTS_ASSERT(a_scan_ends, i_clk, i_rst_n, (r_state == S_SCAN && i_status.scan_last) |=> (r_state == S_DRAIN), "scan overran the last slot")
    `SRTS_ASSERT(a_out_frees, i_clk, i_rst_n, (r_state == S_OUT) |=> !r_busy, "busy held after the result")
    `SRTS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE && !r_busy), "reset did not idle the controller")

endmodule

// File: hw/rtl/shortest_remaining_time_scheduler.sv
// Load transfer: taken while idle, busy stays low, so loads may run back to back.
// Tick transfer: busy through the scan (one RAM read per slot), a drain and an update,
// plus turnaround and output states when a job finishes; the output state strobes the result.
// The scan through each job RAM's single read port sets a tick's length; RAMs are not reset.
// Synchronous active-low reset zeroes time, finish count, loaded flags; job count goes to one.
// The receiver cannot stall: each result is shown for exactly one cycle.
module shortest_remaining_time_scheduler #(
    parameter int MAX_JOBS = srts_pkg::MAX_JOBS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command channel
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_operation,
    input  logic [srts_pkg::SLOT_FIELD_W-1:0] i_job_slot,
    input  logic [srts_pkg::TIME_W-1:0]       i_arrival_time,
    input  logic [srts_pkg::BURST_W-1:0]      i_burst_length,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [srts_pkg::COUNT_W-1:0]      i_job_count,
    // results
    output logic                              o_result_valid,
    output logic [srts_pkg::SLOT_FIELD_W-1:0] o_finished_slot,
    output logic [srts_pkg::TIME_W-1:0]       o_completion_time,
    output logic [srts_pkg::TIME_W-1:0]       o_turnaround_time,
    output logic [srts_pkg::TIME_W-1:0]       o_waiting_time,
    output logic                              o_all_done
);

    import srts_pkg::*;

    // Commands flow down from the controller, status flows back up.
    t_cmd    cmd;
    t_status status;

    // Sequence each transfer: decode loads in place, walk the slots on a tick.
    srts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .busy        (busy),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // Hold the job tables, time and counts; pick the shortest remaining job
    // one slot per cycle and form the completion figures.
    srts_datapath #(.MAX_JOBS(MAX_JOBS)) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_we),
        .i_job_count       (i_job_count),
        .i_job_slot        (i_job_slot),
        .i_arrival_time    (i_arrival_time),
        .i_burst_length    (i_burst_length),
        .o_result_valid    (o_result_valid),
        .o_finished_slot   (o_finished_slot),
        .o_completion_time (o_completion_time),
        .o_turnaround_time (o_turnaround_time),
        .o_waiting_time    (o_waiting_time),
        .o_all_done        (o_all_done)
    );

endmodule
